>>> sv/lrukv_pkg.sv
`timescale 1ns / 1ps
package lrukv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CAP_W           = 5;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
    logic load_out;
  } ctl_cmd_t;

endpackage

>>> sv/lrukv_ctrl.sv
`timescale 1ns / 1ps
module lrukv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lrukv_pkg::ctl_cmd_t cmd
);
  import lrukv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state_r == S_IDLE) && in_valid && !in_stall_r;
    cmd.lookup   = (state_r == S_LOOKUP);
    cmd.update   = (state_r == S_UPDATE);
    cmd.load_out = (state_r == S_RESP) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (cmd.capture) state_nxt = S_LOOKUP;
      S_LOOKUP: state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_RESP;
      S_RESP:   if (cmd.load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_capture_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_LOOKUP))
    else $error("transfer in did not start a lookup");

  a_resp_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_valid_r && out_stall) |=> (state_r == S_RESP))
    else $error("result overwrote a pending transfer");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall_r)
    else $error("input open while busy");
`endif

endmodule

>>> sv/lrukv_dp.sv
`timescale 1ns / 1ps
module lrukv_dp #(
  parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrukv_pkg::ctl_cmd_t                 cmd,
  input  logic                                cfg_valid,
  input  logic [lrukv_pkg::CAP_W-1:0]         cfg_capacity_in_use,
  input  logic                                in_cmd,
  input  logic signed [lrukv_pkg::KEY_W-1:0]  in_key,
  input  logic signed [lrukv_pkg::VAL_W-1:0]  in_write_value,
  output logic                                out_hit,
  output logic signed [lrukv_pkg::VAL_W-1:0]  out_read_value
);
  import lrukv_pkg::*;

  localparam int IDXW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANKW = IDXW;
  localparam int FILLW = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW  = (FILLW > CAP_W) ? FILLW : CAP_W;

  logic [CAP_W-1:0]       cap_r;
  logic                   req_cmd_r;
  logic [KEY_W-1:0]       req_key_r;
  logic [VAL_W-1:0]       req_wval_r;

  logic [KEY_W-1:0]       key_r   [MAX_ENTRIES];
  logic [RANKW-1:0]       rank_r  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [FILLW-1:0]       fill_count_r;
  logic [VAL_W-1:0]       val_mem [MAX_ENTRIES];
  logic [VAL_W-1:0]       rd_r;

  logic [MAX_ENTRIES-1:0] match;
  logic [IDXW-1:0]        hit_idx, free_idx, victim_idx;
  logic [FILLW-1:0]       fill_last;
  logic [CMPW-1:0]        cap_ext, eff_cap;
  logic                   has_room;

  logic                   lk_hit_nxt, lk_upd_nxt, lk_all_nxt, lk_new_nxt, lk_wkey_nxt;
  logic [IDXW-1:0]        lk_slot_nxt;
  logic [RANKW-1:0]       lk_below_nxt;
  logic                   lk_hit_r, lk_upd_r, lk_all_r, lk_new_r, lk_wkey_r;
  logic [IDXW-1:0]        lk_slot_r;
  logic [RANKW-1:0]       lk_below_r;

  logic                   out_hit_r;
  logic [VAL_W-1:0]       out_read_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_capacity_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd_r  <= in_cmd;
      req_key_r  <= in_key;
      req_wval_r <= in_write_value;
    end
  end

  assign fill_last = fill_count_r - FILLW'(1);

  always_comb begin
    cap_ext = CMPW'(cap_r);
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
      eff_cap = CMPW'(MAX_ENTRIES);
    end
    has_room = CMPW'(fill_count_r) < eff_cap;
  end

  always_comb begin
    match      = '0;
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == req_key_r);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDXW'(i);
      if (!valid_r[i]) free_idx = IDXW'(i);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (valid_r[i] && rank_r[i] == RANKW'(fill_last)) victim_idx = IDXW'(i);
    end
  end

  always_comb begin
    lk_hit_nxt   = |match;
    lk_upd_nxt   = 1'b0;
    lk_all_nxt   = 1'b0;
    lk_new_nxt   = 1'b0;
    lk_wkey_nxt  = 1'b0;
    lk_slot_nxt  = hit_idx;
    lk_below_nxt = rank_r[hit_idx];
    if (|match) begin
      lk_upd_nxt = 1'b1;
    end else if (req_cmd_r == CMD_SET) begin
      lk_upd_nxt  = 1'b1;
      lk_wkey_nxt = 1'b1;
      if (has_room) begin
        lk_slot_nxt = free_idx;
        lk_all_nxt  = 1'b1;
        lk_new_nxt  = 1'b1;
      end else if (|valid_r) begin
        lk_slot_nxt  = victim_idx;
        lk_below_nxt = rank_r[victim_idx];
      end else begin
        lk_slot_nxt = '0;
        lk_all_nxt  = 1'b1;
        lk_new_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_upd_r <= 1'b0;
    end else if (cmd.lookup) begin
      lk_upd_r <= lk_upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      lk_hit_r   <= lk_hit_nxt;
      lk_all_r   <= lk_all_nxt;
      lk_new_r   <= lk_new_nxt;
      lk_wkey_r  <= lk_wkey_nxt;
      lk_slot_r  <= lk_slot_nxt;
      lk_below_r <= lk_below_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      fill_count_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.update && lk_upd_r) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDXW'(i) == lk_slot_r) begin
          rank_r[i] <= '0;
        end else if (valid_r[i] && (lk_all_r || rank_r[i] < lk_below_r)) begin
          rank_r[i] <= rank_r[i] + RANKW'(1);
        end
      end
      if (lk_new_r) begin
        valid_r[lk_slot_r] <= 1'b1;
        fill_count_r       <= fill_count_r + FILLW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && lk_wkey_r) begin
      key_r[lk_slot_r] <= req_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rd_r <= val_mem[lk_slot_r];
      if (lk_upd_r && req_cmd_r == CMD_SET) begin
        val_mem[lk_slot_r] <= req_wval_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r        <= lk_hit_r;
      out_read_value_r <= (lk_hit_r && req_cmd_r == CMD_GET) ? rd_r : MISS_VALUE;
    end
  end

  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

`ifndef ASSERT_OFF
  a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |-> $onehot0(match))
    else $error("key present in more than one entry");

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(fill_count_r))
    else $error("fill count out of step with valid entries");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_count_r) <= MAX_ENTRIES)
    else $error("fill count above entry count");

  a_new_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && lk_upd_r && lk_new_r) |-> !valid_r[lk_slot_r])
    else $error("fill into an occupied entry");
`endif

endmodule

>>> sv/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// Channel | Ports                                        | Direction
// in      | in_valid, in_stall, in_cmd, in_key,          | request in
//         | in_write_value                               |
// out     | out_valid, out_stall, out_hit, out_read_value| result out
// cfg     | cfg_valid, cfg_ready, cfg_capacity_in_use    | register write
//
// Each request passes in turn through transfer, key compare,
// rank/state update with value memory read, result register load.
// rst_n is synchronous: clears valid bits, ranks, fill count, capacity to 16.
// A stalled result holds in the output register; one more request can be
// taken and waits for it at the result load step. cfg_ready is always high.
module lru_key_value_cache_core #(
  parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic signed [lrukv_pkg::KEY_W-1:0]  in_key,
  input  logic signed [lrukv_pkg::VAL_W-1:0]  in_write_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic signed [lrukv_pkg::VAL_W-1:0]  out_read_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrukv_pkg::CAP_W-1:0]         cfg_capacity_in_use
);
  import lrukv_pkg::*;

  ctl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  lrukv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lrukv_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_valid           (cfg_valid),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .in_cmd              (in_cmd),
    .in_key              (in_key),
    .in_write_value      (in_write_value),
    .out_hit             (out_hit),
    .out_read_value      (out_read_value)
  );

endmodule

>>> test/lru_key_value_cache_core_tb.sv
`timescale 1ns / 1ps
module lru_key_value_cache_core_tb;
  import lrukv_pkg::*;

  localparam int NE = MAX_ENTRIES_DEF;

  typedef struct {
    bit             cmd;
    bit [KEY_W-1:0] key;
    bit [VAL_W-1:0] wval;
  } request_t;

  typedef struct {
    bit             hit;
    bit [VAL_W-1:0] read_value;
  } lookup_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_cmd = CMD_GET;
  logic signed [KEY_W-1:0]  in_key = '0;
  logic signed [VAL_W-1:0]  in_write_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_hit;
  logic signed [VAL_W-1:0]  out_read_value;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_capacity_in_use = '0;

  lru_key_value_cache_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_key              (in_key),
    .in_write_value      (in_write_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_read_value      (out_read_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use)
  );

  // cache shadow state
  bit [KEY_W-1:0] shadow_key [NE];
  bit [VAL_W-1:0] shadow_val [NE];
  bit             shadow_vld [NE];
  int unsigned    shadow_rank [NE];
  int unsigned    shadow_fill;
  bit [CAP_W-1:0] shadow_cap;

  request_t request_queue[$];
  lookup_t  expected_lookups[$];
  int       error_count = 0;
  bit       req_taken = 1'b0;
  bit       long_hold_go = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void make_recent(int s, int unsigned below);
    for (int i = 0; i < NE; i++) begin
      if (shadow_vld[i] && i != s && shadow_rank[i] < below) shadow_rank[i] += 1;
    end
    shadow_rank[s] = 0;
  endfunction

  task automatic cache_access(input request_t r, output lookup_t res);
    int          found;
    int          slot;
    int unsigned worst;
    int unsigned eff;
    bit          any;
    found = -1;
    res.hit = 1'b0;
    res.read_value = MISS_VALUE;
    eff = 32'(shadow_cap);
    if (eff < 1) eff = 1;
    if (eff > NE) eff = NE;
    for (int i = 0; i < NE; i++) begin
      if (found < 0 && shadow_vld[i] && shadow_key[i] == r.key) found = i;
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (r.cmd == CMD_GET) res.read_value = shadow_val[found];
      else shadow_val[found] = r.wval;
      make_recent(found, shadow_rank[found]);
    end else if (r.cmd == CMD_SET) begin
      slot = -1;
      if (shadow_fill < eff) begin
        for (int i = 0; i < NE; i++) begin
          if (slot < 0 && !shadow_vld[i]) slot = i;
        end
        if (slot < 0) slot = 0;
        shadow_vld[slot] = 1'b1;
        shadow_key[slot] = r.key;
        shadow_val[slot] = r.wval;
        make_recent(slot, 32'hFFFF_FFFF);
        shadow_fill += 1;
      end else begin
        worst = 0;
        any = 1'b0;
        slot = 0;
        for (int i = 0; i < NE; i++) begin
          if (shadow_vld[i] && (!any || shadow_rank[i] >= worst)) begin
            worst = shadow_rank[i];
            slot = i;
            any = 1'b1;
          end
        end
        if (!any) begin
          slot = 0;
          shadow_vld[slot] = 1'b1;
          shadow_fill += 1;
          worst = 32'hFFFF_FFFF;
        end
        shadow_key[slot] = r.key;
        shadow_val[slot] = r.wval;
        make_recent(slot, worst);
      end
    end
  endtask

  // request acceptance, prediction and result checking
  always @(posedge clk) begin
    request_t r;
    lookup_t  res;
    lookup_t  exp_res;
    if (!rst_n) begin
      req_taken = 1'b0;
      for (int i = 0; i < NE; i++) begin
        shadow_vld[i] = 1'b0;
        shadow_rank[i] = 0;
        shadow_key[i] = '0;
        shadow_val[i] = '0;
      end
      shadow_fill = 0;
      shadow_cap = CAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) shadow_cap = cfg_capacity_in_use;
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        r.cmd = in_cmd;
        r.key = in_key;
        r.wval = in_write_value;
        cache_access(r, res);
        expected_lookups.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          $error("unexpected result transfer: hit %0d read_value %h", out_hit, out_read_value);
          error_count++;
        end else begin
          exp_res = expected_lookups.pop_front();
          if (out_hit !== exp_res.hit) begin
            $error("hit: expected %0d, actual %0d", exp_res.hit, out_hit);
            error_count++;
          end
          if (out_read_value !== exp_res.read_value) begin
            $error("read_value: expected %h, actual %h", exp_res.read_value, out_read_value);
            error_count++;
          end
        end
      end
    end
  end

  // request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !req_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (request_queue.size() > 0) begin
        r = request_queue.pop_front();
        in_cmd <= r.cmd;
        in_key <= r.key;
        in_write_value <= r.wval;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  stall_mode = 0;
  int  mode_left = 0;
  int  stall_tick = 0;
  always @(negedge clk) begin
    stall_tick++;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (long_hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= (stall_tick % 5) < 3;
      endcase
    end
  end

  function automatic void add_request(bit cmd, bit [KEY_W-1:0] key, bit [VAL_W-1:0] wval);
    request_t r;
    r.cmd = cmd;
    r.key = key;
    r.wval = wval;
    request_queue.push_back(r);
  endfunction

  function automatic bit [31:0] edge_word();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || expected_lookups.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(input bit [CAP_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity_in_use <= v;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit [CAP_W-1:0] caps [10];
    bit [KEY_W-1:0] key_pool [$];
    bit [KEY_W-1:0] k;
    bit [VAL_W-1:0] v;
    int             pick;
    caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd7, 5'd2, 5'd16, 5'd12, 5'd3};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default capacity: extremes, overwrite, hit with an all-ones value
    add_request(CMD_GET, 32'h8000_0000, $urandom);
    add_request(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    add_request(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    add_request(CMD_GET, 32'h8000_0000, $urandom);
    add_request(CMD_GET, 32'h7FFF_FFFF, $urandom);
    add_request(CMD_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    add_request(CMD_SET, 32'h0000_0000, 32'h0000_0000);
    add_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    add_request(CMD_GET, 32'hFFFF_FFFF, $urandom);
    add_request(CMD_SET, 32'hFFFF_FFFF, 32'h1234_5678);
    wait_drained();

    // capacity dropped below the fill count
    write_capacity(5'd2);
    add_request(CMD_SET, 32'h5555_5555, 32'hAAAA_AAAA);
    add_request(CMD_GET, 32'h8000_0000, $urandom);
    add_request(CMD_GET, 32'hFFFF_FFFF, $urandom);
    add_request(CMD_SET, 32'hAAAA_AAAA, 32'h5555_5555);
    add_request(CMD_GET, 32'h5555_5555, $urandom);
    wait_drained();

    // zero capacity behaves as one
    write_capacity(5'd0);
    add_request(CMD_SET, 32'd1, 32'd1);
    add_request(CMD_SET, 32'd2, 32'd2);
    add_request(CMD_GET, 32'd1, $urandom);
    add_request(CMD_GET, 32'd2, $urandom);
    wait_drained();

    // capacity above the store size
    write_capacity(5'd31);
    add_request(CMD_SET, 32'd3, 32'hDEAD_BEEF);
    add_request(CMD_SET, 32'd4, 32'h0BAD_F00D);
    add_request(CMD_GET, 32'd3, $urandom);
    add_request(CMD_GET, 32'h5555_5555, $urandom);
    wait_drained();

    foreach (caps[p]) begin
      write_capacity(caps[p]);
      key_pool.delete();
      repeat ($urandom_range(1, 20)) key_pool.push_back($urandom);
      if ($urandom_range(0, 1)) key_pool.push_back(edge_word());
      for (int n = 0; n < 65; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (pick < 92) k = $urandom;
        else k = edge_word();
        v = ($urandom_range(0, 9) == 0) ? edge_word() : $urandom;
        add_request(1'($urandom_range(0, 1)), k, v);
      end
      if (p == 0) long_hold_go = 1'b1;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_lookups.size() == 0) begin
      $display("lru_key_value_cache_core verification clean");
    end else begin
      $display("lru_key_value_cache_core verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("lru_key_value_cache_core verification failed");
    $finish;
  end

endmodule
